// ===== rtl/core/mstb_pkg.sv =====
// package for the millisecond timebase: constants, codes and beat structs
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package mstb_pkg;

	localparam int TICKS_PER_SECOND = 1000;
	localparam int LED_GAP_TICKS    = 62;
	localparam int MS_W             = 10;
	localparam int GAP_W            = 6;

	localparam logic [MS_W-1:0]  TICKS_LIMIT = MS_W'(TICKS_PER_SECOND);
	localparam logic [GAP_W-1:0] GAP_RELOAD  = GAP_W'(LED_GAP_TICKS);

	localparam logic [15:0] MASK_START = 16'h8000;
	localparam logic [15:0] MARK_FIRST = 16'hF000;
	localparam logic [15:0] MARK_REST  = 16'h8000;

	localparam logic [5:0] SEC_LAST  = 6'd59;
	localparam logic [5:0] MIN_LAST  = 6'd59;
	localparam logic [4:0] HOUR_LAST = 5'd23;

	localparam logic [1:0] FUNC_TICK = 2'd0;
	localparam logic [1:0] FUNC_LOAD = 2'd1;
	localparam logic [1:0] FUNC_FIX  = 2'd2;
	localparam logic [1:0] FUNC_ARM  = 2'd3;

	localparam int ADDR_W = 5;

	localparam logic [2:0] REG_PAT_ONE   = 3'd0;
	localparam logic [2:0] REG_PAT_TWO   = 3'd1;
	localparam logic [2:0] REG_PAT_THREE = 3'd2;
	localparam logic [2:0] REG_PAT_FOUR  = 3'd3;
	localparam logic [2:0] REG_MUX_MODE  = 3'd4;

	typedef struct packed {
		logic [1:0]  func;
		logic [5:0]  set_sec;
		logic [5:0]  set_min;
		logic [4:0]  set_hour;
		logic [4:0]  set_day;
		logic [3:0]  set_month;
		logic [5:0]  set_year;
		logic [15:0] online_seconds;
	} in_t;

	typedef struct packed {
		logic [3:0]  led_lines;
		logic        second_pulse;
		logic [15:0] tick_count;
		logic [15:0] seconds_count;
		logic [5:0]  clock_sec;
		logic [5:0]  clock_min;
		logic [4:0]  clock_hour;
		logic [4:0]  clock_day;
		logic [3:0]  clock_month;
		logic [5:0]  clock_year;
		logic        online_flag;
	} out_t;

	typedef struct packed {
		logic [15:0] pat_one;
		logic [15:0] pat_two;
		logic [15:0] pat_three;
		logic [15:0] pat_four;
		logic        mux_mode;
	} cfg_t;

	typedef struct packed {
		logic tick_fire;
		logic second;
	} step_t;

	typedef struct packed {
		logic [15:0] tick_count;
		logic [15:0] seconds_count;
		logic [5:0]  sec;
		logic [5:0]  min;
		logic [4:0]  hour;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [5:0]  year;
		logic        online;
	} tod_t;

endpackage

// ===== rtl/core/mstb_cfg.sv =====
// configuration register file with apb-style access
// depends on mstb_pkg
`timescale 1ns / 1ps

module mstb_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [mstb_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output mstb_pkg::cfg_t            cfg
);

	mstb_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				mstb_pkg::REG_PAT_ONE:   cfg_q.pat_one   <= pwdata[15:0];
				mstb_pkg::REG_PAT_TWO:   cfg_q.pat_two   <= pwdata[15:0];
				mstb_pkg::REG_PAT_THREE: cfg_q.pat_three <= pwdata[15:0];
				mstb_pkg::REG_PAT_FOUR:  cfg_q.pat_four  <= pwdata[15:0];
				mstb_pkg::REG_MUX_MODE:  cfg_q.mux_mode  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			mstb_pkg::REG_PAT_ONE:   prdata = {16'd0, cfg_q.pat_one};
			mstb_pkg::REG_PAT_TWO:   prdata = {16'd0, cfg_q.pat_two};
			mstb_pkg::REG_PAT_THREE: prdata = {16'd0, cfg_q.pat_three};
			mstb_pkg::REG_PAT_FOUR:  prdata = {16'd0, cfg_q.pat_four};
			mstb_pkg::REG_MUX_MODE:  prdata = {31'd0, cfg_q.mux_mode};
			default:                 prdata = 32'd0;
		endcase
	end

endmodule

// ===== rtl/core/mstb_clock.sv =====
// millisecond and seconds counters, time of day, gps fix skip, online timeout
// depends on mstb_pkg
`timescale 1ns / 1ps

module mstb_clock (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  mstb_pkg::in_t        item,
	output mstb_pkg::step_t      step,
	output mstb_pkg::tod_t       tod_nxt
);

	logic [mstb_pkg::MS_W-1:0] ms_q, ms_n;
	logic [15:0]               left_q, left_n;
	logic                      fix_q, fix_n;
	mstb_pkg::tod_t            tod_q, tod_n;
	logic                      second;

	always_comb begin
		ms_n   = ms_q;
		left_n = left_q;
		fix_n  = fix_q;
		tod_n  = tod_q;
		second = 1'b0;
		case (item.func)
			mstb_pkg::FUNC_TICK: begin
				tod_n.tick_count = tod_q.tick_count + 16'd1;
				ms_n = ms_q + mstb_pkg::MS_W'(1);
				if (ms_n >= mstb_pkg::TICKS_LIMIT) begin
					second = 1'b1;
					ms_n = '0;
					tod_n.seconds_count = tod_q.seconds_count + 16'd1;
					if (fix_q) begin
						fix_n = 1'b0;
					end else if (tod_q.sec >= mstb_pkg::SEC_LAST) begin
						tod_n.sec = '0;
						if (tod_q.min >= mstb_pkg::MIN_LAST) begin
							tod_n.min = '0;
							if (tod_q.hour >= mstb_pkg::HOUR_LAST) begin
								tod_n.hour = '0;
								tod_n.day  = tod_q.day + 5'd1;
							end else begin
								tod_n.hour = tod_q.hour + 5'd1;
							end
						end else begin
							tod_n.min = tod_q.min + 6'd1;
						end
					end else begin
						tod_n.sec = tod_q.sec + 6'd1;
					end
					if (tod_q.online) begin
						if (left_q != 16'd0) begin
							left_n = left_q - 16'd1;
						end else begin
							tod_n.online = 1'b0;
						end
					end
				end
			end
			mstb_pkg::FUNC_LOAD: begin
				if (item.set_day != tod_q.day) begin
					tod_n.sec   = item.set_sec;
					tod_n.min   = item.set_min;
					tod_n.hour  = item.set_hour;
					tod_n.day   = item.set_day;
					tod_n.month = item.set_month;
					tod_n.year  = item.set_year;
				end
			end
			mstb_pkg::FUNC_FIX: begin
				fix_n = 1'b1;
			end
			mstb_pkg::FUNC_ARM: begin
				left_n       = item.online_seconds;
				tod_n.online = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ms_q   <= '0;
			left_q <= '0;
			fix_q  <= 1'b0;
			tod_q  <= '0;
		end else if (fire) begin
			ms_q   <= ms_n;
			left_q <= left_n;
			fix_q  <= fix_n;
			tod_q  <= tod_n;
		end
	end

	assign step.tick_fire = fire && (item.func == mstb_pkg::FUNC_TICK);
	assign step.second    = fire && second;
	assign tod_nxt        = tod_n;

endmodule

// ===== rtl/core/mstb_led.sv =====
// walking mask led blinker with direct and marker/mux display modes
// depends on mstb_pkg
`timescale 1ns / 1ps

module mstb_led (
	input  logic            clk,
	input  logic            arst_n,
	input  mstb_pkg::step_t step,
	input  mstb_pkg::cfg_t  cfg,
	output logic [3:0]      led_nxt
);

	logic [15:0]                mask_q, mask_n, mask_pre, mask_sh;
	logic [mstb_pkg::GAP_W-1:0] gap_q, gap_n;
	logic [1:0]                 frame_q, frame_n;
	logic [3:0]                 led_q, led_n;
	logic [15:0]                pat_sel, mark;

	always_comb begin
		case (frame_q)
			2'd0:    pat_sel = cfg.pat_one;
			2'd1:    pat_sel = cfg.pat_two;
			2'd2:    pat_sel = cfg.pat_three;
			default: pat_sel = cfg.pat_four;
		endcase
	end

	assign mark     = (frame_q == 2'd0) ? mstb_pkg::MARK_FIRST : mstb_pkg::MARK_REST;
	assign mask_pre = step.second ? mstb_pkg::MASK_START : mask_q;
	assign mask_sh  = mask_pre >> 1;

	always_comb begin
		mask_n  = mask_q;
		gap_n   = gap_q;
		frame_n = frame_q;
		led_n   = led_q;
		if (step.tick_fire) begin
			mask_n = mask_pre;
			if (gap_q != '0) begin
				gap_n = gap_q - mstb_pkg::GAP_W'(1);
			end else if (mask_pre != 16'd0) begin
				if (cfg.mux_mode) begin
					led_n = {2'b00, |(mask_pre & pat_sel), |(mask_pre & mark)};
				end else begin
					led_n = {|(mask_pre & cfg.pat_four), |(mask_pre & cfg.pat_three),
					         |(mask_pre & cfg.pat_two), |(mask_pre & cfg.pat_one)};
				end
				mask_n = mask_sh;
				if (mask_sh != 16'd0) begin
					gap_n = mstb_pkg::GAP_RELOAD;
				end else if (cfg.mux_mode) begin
					frame_n = frame_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '0;
			gap_q   <= '0;
			frame_q <= '0;
			led_q   <= '0;
		end else begin
			mask_q  <= mask_n;
			gap_q   <= gap_n;
			frame_q <= frame_n;
			led_q   <= led_n;
		end
	end

	assign led_nxt = led_n;

endmodule

// ===== rtl/core/ms_timebase_clock_led_blinker_unit.sv =====
// Millisecond timebase with time-of-day clock, online timeout and LED blinker.
// One item is accepted every clock cycle while in_stall is low; it waits in the input
// register and moves to the result register once that register is empty or its beat
// is not stalled, and its result beat is then offered from the result register.
// A stalled result holds the next item in the input register, which stalls input.
// All counter and LED state updates as the item leaves the input register.
// Every item gives exactly one result beat showing the state after that item.
// Configuration registers sit at byte addresses 0, 4, 8, 12, 16.
// depends on mstb_pkg, mstb_cfg, mstb_clock, mstb_led
`timescale 1ns / 1ps

module ms_timebase_clock_led_blinker_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  mstb_pkg::in_t               in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output mstb_pkg::out_t              out_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mstb_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	logic            valid_s1;
	mstb_pkg::in_t   item_s1;
	logic            out_valid_q;
	mstb_pkg::out_t  out_data_q;
	logic            fire;
	mstb_pkg::cfg_t  cfg;
	mstb_pkg::step_t step;
	mstb_pkg::tod_t  tod_nxt;
	logic [3:0]      led_nxt;

	assign fire     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !fire;

	mstb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mstb_clock u_clock (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item    (item_s1),
		.step    (step),
		.tod_nxt (tod_nxt)
	);

	mstb_led u_led (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.cfg     (cfg),
		.led_nxt (led_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q.led_lines     <= led_nxt;
			out_data_q.second_pulse  <= step.second;
			out_data_q.tick_count    <= tod_nxt.tick_count;
			out_data_q.seconds_count <= tod_nxt.seconds_count;
			out_data_q.clock_sec     <= tod_nxt.sec;
			out_data_q.clock_min     <= tod_nxt.min;
			out_data_q.clock_hour    <= tod_nxt.hour;
			out_data_q.clock_day     <= tod_nxt.day;
			out_data_q.clock_month   <= tod_nxt.month;
			out_data_q.clock_year    <= tod_nxt.year;
			out_data_q.online_flag   <= tod_nxt.online;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	// stall only with a beat held in the input register
	assert property (@(posedge clk) disable iff (!arst_n) in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	// a moved beat always lands in the result register
	assert property (@(posedge clk) disable iff (!arst_n) fire |=> out_valid_q)
		else $error("result beat lost");

	// second boundary shows up as second_pulse on the matching result beat
	assert property (@(posedge clk) disable iff (!arst_n)
		step.second |=> out_data_q.second_pulse)
		else $error("second pulse missing from result");

	// second boundary only on a tick
	assert property (@(posedge clk) disable iff (!arst_n)
		step.second |-> step.tick_fire)
		else $error("second boundary without tick");
`endif

endmodule
